// ===== rtl/ula_pkg.sv =====
// Shared types and constants for the serial line assembler queue.
// Used by ula_ctrl, ula_dp and the top level; no dependencies.
package ula_pkg;

  localparam int LINE_BYTES  = 64;
  localparam int QUEUE_LINES = 4;

  // One spare row is kept for the line being gathered, so it never overlaps a queued line.
  localparam int ROWS      = QUEUE_LINES + 1;
  localparam int PTR_W     = $clog2(ROWS);
  localparam int LEN_W     = $clog2(LINE_BYTES);
  localparam int ADDR_W    = PTR_W + LEN_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  localparam logic FUNC_RX  = 1'b0;
  localparam logic FUNC_POP = 1'b1;

  typedef struct packed {
    logic rx_take;    // store or act on a received byte
    logic pop_start;  // begin a pop request, fetch first character
    logic pop_next;   // current character taken, fetch the next one
    logic pop_done;   // final result taken, retire the line
  } cmd_t;

  typedef struct packed {
    logic last;       // the result on show is the final one of the pop
  } sts_t;

endpackage

// ===== rtl/uart_line_assembler_queue.sv =====
// Serial line assembler queue: gathers received bytes into lines, queues them, streams on pop.
// A byte is written on acceptance; a pop shows its first result in the cycle after acceptance.
// Throughput: one byte per cycle while idle; a pop streams 1 character per cycle (line memory
// read port) while out_ready holds; requests resume the cycle after its last result is taken.
// Reset: rst_n synchronous, active low; clears counts, pointers and the overflow flag.
// No clearing pass: line memory and lengths are used only after being written.
module uart_line_assembler_queue (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char_out,
  output logic [5:0] out_line_length,
  output logic       out_status,
  output logic       out_overflow_seen,
  output logic       out_last
);

  // Command and status between the state machine and the datapath.
  ula_pkg::cmd_t cmd;
  ula_pkg::sts_t sts;

  // Controller: accepts requests while idle, holds off new requests while a pop streams.
  ula_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Datapath: line memory with a spare row for the line being gathered, ring of queued
  // lines, sticky overflow; the registered memory read is the output register.
  ula_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .rx_byte       (in_rx_byte),
    .sts           (sts),
    .char_out      (out_char_out),
    .line_length   (out_line_length),
    .status        (out_status),
    .overflow_seen (out_overflow_seen),
    .last          (out_last)
  );

endmodule

// ===== rtl/ula_ctrl.sv =====
// Controller for the line assembler queue: idle/stream state machine.
// Depends on ula_pkg for cmd_t and sts_t.
module ula_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_func,
  input  logic          out_ready,
  input  ula_pkg::sts_t sts,
  output logic          in_ready,
  output logic          out_valid,
  output ula_pkg::cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_SHOW
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   in_take;
  logic   out_take;

  assign in_take  = in_valid && in_ready_r;
  assign out_take = out_valid_r && out_ready;

  always_comb begin
    cmd           = '0;
    cmd.rx_take   = in_take && (in_func == ula_pkg::FUNC_RX);
    cmd.pop_start = in_take && (in_func == ula_pkg::FUNC_POP);
    cmd.pop_next  = out_take && !sts.last;
    cmd.pop_done  = out_take && sts.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.pop_start) begin
            state_r     <= ST_SHOW;
            in_ready_r  <= 1'b0;
            out_valid_r <= 1'b1;
          end else begin
            in_ready_r <= 1'b1;
          end
        end
        ST_SHOW: begin
          if (cmd.pop_done) begin
            state_r     <= ST_IDLE;
            in_ready_r  <= 1'b1;
            out_valid_r <= 1'b0;
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          in_ready_r  <= 1'b0;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/ula_dp.sv =====
// Datapath for the line assembler queue: line memory, ring pointers, lengths, flags.
// Depends on ula_pkg; driven by commands from ula_ctrl.
module ula_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  ula_pkg::cmd_t cmd,
  input  logic [7:0]    rx_byte,
  output ula_pkg::sts_t sts,
  output logic [7:0]    char_out,
  output logic [5:0]    line_length,
  output logic          status,
  output logic          overflow_seen,
  output logic          last
);

  logic [7:0]                mem [ula_pkg::MEM_DEPTH];
  logic [ula_pkg::LEN_W-1:0] lens_r [ula_pkg::ROWS];

  logic [ula_pkg::LEN_W-1:0] part_len_r;
  logic [ula_pkg::PTR_W-1:0] wslot_r;
  logic [ula_pkg::PTR_W-1:0] rslot_r;
  logic [ula_pkg::PTR_W-1:0] held_r;
  logic                      ovf_r;

  logic [ula_pkg::LEN_W-1:0] idx_r;
  logic [ula_pkg::LEN_W-1:0] len_r;
  logic                      ovs_r;
  logic                      empty_r;
  logic [7:0]                mem_q_r;

  logic                       is_end;
  logic [ula_pkg::LEN_W-1:0]  idx_inc;
  logic [ula_pkg::LEN_W:0]    idx_plus;
  logic                       last_char;
  logic [ula_pkg::LEN_W-1:0]  rd_col;
  logic [ula_pkg::ADDR_W-1:0] rd_addr;
  logic [ula_pkg::ADDR_W-1:0] wr_addr;
  logic                       wr_en;

  function automatic logic [ula_pkg::PTR_W-1:0] next_slot(input logic [ula_pkg::PTR_W-1:0] s);
    logic [ula_pkg::PTR_W-1:0] n;
    if (s == ula_pkg::PTR_W'(ula_pkg::QUEUE_LINES)) n = '0;
    else                                             n = s + 1'b1;
    return n;
  endfunction

  assign is_end    = (rx_byte == ula_pkg::BYTE_CR) || (rx_byte == ula_pkg::BYTE_LF);
  assign idx_plus  = {1'b0, idx_r} + 1'b1;
  assign idx_inc   = idx_plus[ula_pkg::LEN_W-1:0];
  assign last_char = (idx_plus == {1'b0, len_r});
  assign rd_col    = cmd.pop_start ? '0 : idx_inc;
  assign rd_addr   = {rslot_r, rd_col};
  assign wr_addr   = {wslot_r, part_len_r};
  assign wr_en     = cmd.rx_take && !is_end &&
                     (part_len_r < ula_pkg::LEN_W'(ula_pkg::LINE_BYTES - 1));

  // line memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= rx_byte;
    end
    if (cmd.pop_start || cmd.pop_next) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // assembly and queue control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_len_r <= '0;
      wslot_r    <= '0;
      rslot_r    <= '0;
      held_r     <= '0;
      ovf_r      <= 1'b0;
    end else if (cmd.rx_take) begin
      if (is_end) begin
        if (part_len_r != '0) begin
          if (held_r < ula_pkg::PTR_W'(ula_pkg::QUEUE_LINES)) begin
            wslot_r <= next_slot(wslot_r);
            held_r  <= held_r + 1'b1;
          end else begin
            ovf_r <= 1'b1;
          end
          part_len_r <= '0;
        end
      end else if (wr_en) begin
        part_len_r <= part_len_r + 1'b1;
      end else begin
        part_len_r <= '0;
        ovf_r      <= 1'b1;
      end
    end else if (cmd.pop_start) begin
      ovf_r <= 1'b0;
    end else if (cmd.pop_done && !empty_r) begin
      rslot_r <= next_slot(rslot_r);
      held_r  <= held_r - 1'b1;
    end
  end

  // committed line lengths
  always_ff @(posedge clk) begin
    if (cmd.rx_take && is_end && (part_len_r != '0) &&
        (held_r < ula_pkg::PTR_W'(ula_pkg::QUEUE_LINES))) begin
      lens_r[wslot_r] <= part_len_r;
    end
  end

  // per-pop payload
  always_ff @(posedge clk) begin
    if (cmd.pop_start) begin
      ovs_r   <= ovf_r;
      empty_r <= (held_r == '0);
      len_r   <= lens_r[rslot_r];
      idx_r   <= '0;
    end else if (cmd.pop_next) begin
      idx_r <= idx_inc;
    end
  end

  assign sts.last      = empty_r || last_char;
  assign char_out      = empty_r ? 8'h00 : mem_q_r;
  assign line_length   = empty_r ? 6'd0 : 6'(len_r);
  assign status        = empty_r;
  assign overflow_seen = ovs_r;
  assign last          = empty_r || last_char;

endmodule

// ===== rtl/ula_chk.sv =====
// Port-level checker for the serial line assembler queue, bound to the top level.
// Depends only on the top level's ports.
module ula_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_func,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char_out,
  input logic [5:0] out_line_length,
  input logic       out_status,
  input logic       out_overflow_seen,
  input logic       out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_out) && $stable(out_last))
    else $error("result changed while stalled");

  // no new request taken while a pop streams
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request accepted during a pop");

  // empty status is a single zeroed final result
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last && out_line_length == 6'd0 && out_char_out == 8'd0)
    else $error("malformed empty-status result");

  // a pop keeps length and overflow report across its characters
  a_pop_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && $stable(out_line_length) && $stable(out_overflow_seen) && !out_status)
    else $error("pop fields changed between characters");

endmodule

bind uart_line_assembler_queue ula_chk u_chk (.*);
